FILE: rtl/core/bsa_pkg.sv
`default_nettype none

package bsa_pkg;

  // bitmap word geometry
  localparam int BIT_W     = 5;

  // request codes
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_REALLOC = 2'd2;

  // result codes
  typedef enum logic [2:0] {
    STAT_GRANT          = 3'd0,
    STAT_ALLOC_FALLBACK = 3'd1,
    STAT_RELEASED       = 3'd2,
    STAT_FREE_PASS      = 3'd3,
    STAT_KEPT           = 3'd4,
    STAT_REALLOC_PASS   = 3'd5
  } status_t;

  // control sequencer
  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DIV,
    FSM_CLR_RD,
    FSM_CLR_WR
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/bsa_slot_div.sv
`default_nettype none

// slot of a pool offset by reciprocal multiply: offset latched, then one registered product
module bsa_slot_div #(
  parameter int SLOTS      = 160,
  parameter int SLOT_BYTES = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [$clog2(SLOTS*SLOT_BYTES)-1:0] offset,
  output logic                                  done,
  output logic [$clog2(SLOTS)-1:0]              quotient
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int OFF_W  = $clog2(SLOTS * SLOT_BYTES);
  // rounded-up reciprocal, exact for every offset below 2^OFF_W at this shift
  localparam int SHIFT  = OFF_W + $clog2(SLOT_BYTES);
  localparam int RCP_W  = OFF_W + 2;
  localparam int PROD_W = OFF_W + RCP_W;
  localparam logic [63:0] RCP =
    ((64'd1 << SHIFT) + 64'(SLOT_BYTES) - 64'd1) / 64'(SLOT_BYTES);
  localparam logic [RCP_W-1:0] RCP_L = RCP[RCP_W-1:0];

  logic              run;
  logic [OFF_W-1:0]  off_q;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(off_q) * PROD_W'(RCP_L);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      run  <= start;
      done <= run;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      off_q <= offset;
    end
    if (run) begin
      quotient <= prod[SHIFT +: SLOT_W];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bitmap_slot_allocator.sv
// channel    | direction | handshake          | payload
// -----------+-----------+--------------------+-----------------------------------------
// request    | in        | start & !busy      | cmd, request_size, address, address_null
// result     | out       | done (one cycle)   | status, result_address, slot_index
// pool base  | in        | cfg_we             | cfg_wdata
//
// allocate: the request is latched, then one bitmap word checked per cycle from a streamed
//   read of the single read port of the bitmap, up to the first free slot or the last word
// free / reallocate of a pool block: slot found by reciprocal multiply; a kept block
//   answers once the slot is found, a release adds a read and a write-back of one word
// out-of-pool requests and oversize allocates are answered without going busy
// busy drops in the cycle the result is shown, so a new request may follow at once
// rst (synchronous) clears the used map through per-word valid bits and zeroes pool base
// the result cannot be held off: done pulses for exactly one cycle

`default_nettype none

module bitmap_slot_allocator #(
  parameter int SLOTS      = 160,
  parameter int SLOT_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  // request
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] request_size,
  input  wire logic [31:0] address,
  input  wire logic        address_null,
  // result
  output logic             done,
  output logic [2:0]       status,
  output logic [31:0]      result_address,
  output logic [7:0]       slot_index
);

  localparam int WORDS  = (SLOTS + 31) / 32;
  localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BIT_W  = bsa_pkg::BIT_W;
  localparam int IDX_W  = WORD_W + BIT_W;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SPAN   = SLOTS * SLOT_BYTES;
  localparam int OFF_W  = $clog2(SPAN);

  localparam logic [32:0]       SPAN_L       = 33'(SPAN);
  localparam logic [31:0]       SLOT_BYTES_L = 32'(SLOT_BYTES);
  localparam logic [WORD_W:0]   WORDS_L      = WORDS[WORD_W:0];
  localparam logic [WORD_W-1:0] LAST_WORD    = WORD_W'(WORDS - 1);
  // slots past the end of the pool in the last word count as taken
  localparam logic [31:0] LAST_MASK = (SLOTS % 32 == 0) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << (SLOTS % 32)) - 64'd1);

  bsa_pkg::state_t state, state_next;

  // configuration register
  logic [31:0] pool_base;

  // latched request
  logic [1:0]  cmd_q;
  logic        fits_q;
  logic [31:0] addr_q;
  logic [IDX_W-1:0] slot_q;

  // request decode at accept
  logic        accept;
  logic        is_alloc;
  logic        fits;
  logic [31:0] offset;
  logic        in_pool;

  // bitmap memory and its read side
  logic [31:0]       mem [WORDS];
  logic [WORDS-1:0]  word_valid;
  logic [31:0]       rd_data;
  logic              rd_live;
  logic [31:0]       cur_word;
  logic              rd_en;
  logic [WORD_W-1:0] rd_addr;
  logic              wr_en;
  logic [WORD_W-1:0] wr_addr;
  logic [31:0]       wr_data;

  // scan pipeline: read issue pointer and the word under check
  logic [WORD_W:0]   rd_ptr;
  logic              scan_more;
  logic              scan_issue;
  logic              chk_vld;
  logic [WORD_W-1:0] chk_idx;
  logic [31:0]       free_bits;
  logic              found;
  logic [BIT_W-1:0]  free_bit;
  logic [IDX_W-1:0]  grant_slot;
  logic [31:0]       grant_addr;
  logic              scan_last;

  // slot divider
  logic              div_start;
  logic              div_done;
  logic [SLOT_W-1:0] div_q;
  logic [IDX_W-1:0]  div_slot;
  logic              div_clear;

  // result staging
  logic                 res_fire;
  bsa_pkg::status_t     res_status;
  logic [31:0]          res_addr;
  logic [IDX_W-1:0]     res_slot;

  assign busy     = (state != bsa_pkg::FSM_IDLE);
  assign accept   = start && !busy;
  assign is_alloc = (cmd == bsa_pkg::CMD_ALLOC) ||
                    ((cmd == bsa_pkg::CMD_REALLOC) && address_null);
  assign fits     = (request_size <= SLOT_BYTES_L);
  assign offset   = address - pool_base;
  // membership against the untruncated end of the pool
  assign in_pool  = (address >= pool_base) && ({1'b0, offset} < SPAN_L);

  // unwritten words read as all free
  assign cur_word = rd_live ? rd_data : 32'd0;

  assign scan_more  = (rd_ptr < WORDS_L);
  assign scan_issue = (state == bsa_pkg::FSM_SCAN) && scan_more;
  assign scan_last  = (chk_idx == LAST_WORD);

  // lowest free slot of the checked word
  assign free_bits = ~cur_word & (scan_last ? LAST_MASK : 32'hFFFF_FFFF);
  assign found     = |free_bits;

  always_comb begin
    free_bit = '0;
    for (int i = 31; i >= 0; i--) begin
      if (free_bits[i]) begin
        free_bit = BIT_W'(i);
      end
    end
  end

  assign grant_slot = {chk_idx, free_bit};
  // granted address wraps modulo 2^32
  assign grant_addr = pool_base + 32'(32'(grant_slot) * SLOT_BYTES_L);

  assign div_slot  = IDX_W'(div_q);
  // free, or a reallocate that outgrows its block, clears the slot bit
  assign div_clear = (cmd_q == bsa_pkg::CMD_FREE) || !fits_q;

  bsa_slot_div #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .offset   (offset[OFF_W-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bsa_pkg::FSM_IDLE: begin
        if (accept) begin
          if (is_alloc) begin
            if (fits) begin
              state_next = bsa_pkg::FSM_SCAN;
            end
          end else if ((cmd inside {bsa_pkg::CMD_FREE, bsa_pkg::CMD_REALLOC}) &&
                       in_pool) begin
            state_next = bsa_pkg::FSM_DIV;
          end
        end
      end
      bsa_pkg::FSM_SCAN: begin
        if (chk_vld && (found || scan_last)) begin
          state_next = bsa_pkg::FSM_IDLE;
        end
      end
      bsa_pkg::FSM_DIV: begin
        if (div_done) begin
          state_next = div_clear ? bsa_pkg::FSM_CLR_RD : bsa_pkg::FSM_IDLE;
        end
      end
      bsa_pkg::FSM_CLR_RD: begin
        state_next = bsa_pkg::FSM_CLR_WR;
      end
      bsa_pkg::FSM_CLR_WR: begin
        state_next = bsa_pkg::FSM_IDLE;
      end
      default: begin
        state_next = bsa_pkg::FSM_IDLE;
      end
    endcase
  end

  // datapath control and result staging
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = rd_ptr[WORD_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = chk_idx;
    wr_data    = cur_word;
    div_start  = 1'b0;
    res_fire   = 1'b0;
    res_status = bsa_pkg::STAT_GRANT;
    res_addr   = 32'd0;
    res_slot   = '0;
    case (state)
      bsa_pkg::FSM_IDLE: begin
        if (accept) begin
          if (is_alloc) begin
            if (!fits) begin
              res_fire   = 1'b1;
              res_status = bsa_pkg::STAT_ALLOC_FALLBACK;
            end
          end else if (cmd inside {bsa_pkg::CMD_FREE, bsa_pkg::CMD_REALLOC}) begin
            if (in_pool) begin
              div_start = 1'b1;
            end else begin
              res_fire   = 1'b1;
              res_status = (cmd == bsa_pkg::CMD_FREE) ? bsa_pkg::STAT_FREE_PASS :
                                                        bsa_pkg::STAT_REALLOC_PASS;
            end
          end
        end
      end
      bsa_pkg::FSM_SCAN: begin
        rd_en = scan_more;
        if (chk_vld) begin
          if (found) begin
            wr_en      = 1'b1;
            wr_addr    = chk_idx;
            wr_data    = cur_word | (32'd1 << free_bit);
            res_fire   = 1'b1;
            res_status = bsa_pkg::STAT_GRANT;
            res_addr   = grant_addr;
            res_slot   = grant_slot;
          end else if (scan_last) begin
            res_fire   = 1'b1;
            res_status = bsa_pkg::STAT_ALLOC_FALLBACK;
          end
        end
      end
      bsa_pkg::FSM_DIV: begin
        // a reallocate that still fits keeps its address exactly as given
        if (div_done && !div_clear) begin
          res_fire   = 1'b1;
          res_status = bsa_pkg::STAT_KEPT;
          res_addr   = addr_q;
          res_slot   = div_slot;
        end
      end
      bsa_pkg::FSM_CLR_RD: begin
        rd_en   = 1'b1;
        rd_addr = slot_q[IDX_W-1:BIT_W];
      end
      bsa_pkg::FSM_CLR_WR: begin
        wr_en    = 1'b1;
        wr_addr  = slot_q[IDX_W-1:BIT_W];
        wr_data  = cur_word & ~(32'd1 << slot_q[BIT_W-1:0]);
        res_fire = 1'b1;
        if (cmd_q == bsa_pkg::CMD_FREE) begin
          res_status = bsa_pkg::STAT_RELEASED;
          res_slot   = slot_q;
        end else begin
          res_status = bsa_pkg::STAT_ALLOC_FALLBACK;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bsa_pkg::FSM_IDLE;
      pool_base  <= 32'd0;
      word_valid <= '0;
      done       <= 1'b0;
      chk_vld    <= 1'b0;
      rd_ptr     <= '0;
    end else begin
      state   <= state_next;
      done    <= res_fire;
      chk_vld <= scan_issue;
      if (cfg_we) begin
        pool_base <= cfg_wdata;
      end
      if (wr_en) begin
        word_valid[wr_addr] <= 1'b1;
      end
      if (accept) begin
        rd_ptr <= '0;
      end else if (scan_issue) begin
        rd_ptr <= rd_ptr + (WORD_W + 1)'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd;
      fits_q <= fits;
      addr_q <= address;
    end
    if (scan_issue) begin
      chk_idx <= rd_ptr[WORD_W-1:0];
    end
    if (state == bsa_pkg::FSM_DIV && div_done) begin
      slot_q <= div_slot;
    end
    if (res_fire) begin
      status         <= res_status;
      result_address <= res_addr;
      slot_index     <= 8'(res_slot);
    end
  end

  // used-bit map, one synchronous read port and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_live <= word_valid[rd_addr];
    end
  end

  // a result always closes the request, so the block is free while it shows
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while a request is still in progress");

  // a grant flips exactly one free bit of the word it read
  a_grant_one_bit: assert property (@(posedge clk) disable iff (rst)
    (wr_en && state == bsa_pkg::FSM_SCAN) |-> ($countones(wr_data ^ cur_word) == 1))
    else $error("grant write-back changes other than one bit");

  // the divider only finishes while the sequencer waits for it
  a_div_in_step: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == bsa_pkg::FSM_DIV))
    else $error("slot divide finished outside its wait state");

  // clearing always reads the same word it then writes
  a_clear_pair: assert property (@(posedge clk) disable iff (rst)
    (state == bsa_pkg::FSM_CLR_WR) |-> ($past(state) == bsa_pkg::FSM_CLR_RD))
    else $error("clear write-back without its read");

endmodule

`default_nettype wire
